[rtl/sequence_alignment_linear_gap_assert.svh]
// Assertion macros used by the alignment block's port-level checker.
`ifndef SEQUENCE_ALIGNMENT_LINEAR_GAP_ASSERT_SVH
`define SEQUENCE_ALIGNMENT_LINEAR_GAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swlg check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swlg check failed");

`endif

[rtl/swlg_pkg.sv]
// Types, codes and constants shared by the alignment block.
package swlg_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int SCORE_W     = 14;
	localparam int CAND_W      = SCORE_W + 2;

	localparam logic [7:0] GAP_CHAR = 8'd45;

	localparam logic [1:0] MV_ORIGIN = 2'd0;
	localparam logic [1:0] MV_LEFT   = 2'd1;
	localparam logic [1:0] MV_UP     = 2'd2;
	localparam logic [1:0] MV_DIAG   = 2'd3;

	localparam logic [1:0] CMD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_ALIGN  = 2'd2;

	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	typedef struct packed {
		logic signed [7:0] match_s;
		logic signed [7:0] mismatch_s;
		logic signed [7:0] gap_s;
	} swlg_scores_t;

	// Row token travelling along the cell chain
	typedef struct packed {
		logic       valid;
		logic       last_row;
		logic [7:0] sym;
	} swlg_flow_t;

endpackage

[rtl/swlg_cell.sv]
// One column cell of the systolic score array, with its own column of moves.
module swlg_cell import swlg_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 b_we,
	input  logic [7:0]           b_in,
	input  swlg_scores_t         scores,
	input  logic                 last_col,
	input  swlg_flow_t           flow_in,
	input  logic [$clog2(MAX_LEN+1)-1:0] row_in,
	input  logic [SCORE_W-1:0]   left_in,
	input  logic [SCORE_W-1:0]   diag_in,
	input  logic [$clog2(MAX_LEN+1)-1:0] rd_row,
	output swlg_flow_t           flow_out,
	output logic [$clog2(MAX_LEN+1)-1:0] row_out,
	output logic [SCORE_W-1:0]   score_out,
	output logic [SCORE_W-1:0]   diag_out,
	output logic [1:0]           rd_move
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int PADW  = CAND_W - SCORE_W;

	logic [7:0]         b_q;
	logic               valid_q;
	logic               last_q;
	logic [7:0]         sym_q;
	logic [LEN_W-1:0]   row_q;
	logic [SCORE_W-1:0] score_q;
	logic [SCORE_W-1:0] diag_q;
	logic [1:0]         mv_mem [0:MAX_LEN];
	logic [1:0]         rd_q;

	logic signed [CAND_W-1:0] gap_x, left_c, up_c, diag_c, best;
	logic [1:0]               mv;

	always_comb begin
		gap_x  = {{(CAND_W-8){scores.gap_s[7]}}, scores.gap_s};
		left_c = $signed({{PADW{1'b0}}, left_in}) + (flow_in.last_row ? '0 : gap_x);
		up_c   = $signed({{PADW{1'b0}}, score_q}) + (last_col ? '0 : gap_x);
		if (flow_in.sym == b_q) begin
			diag_c = $signed({{PADW{1'b0}}, diag_in})
				+ {{(CAND_W-8){scores.match_s[7]}}, scores.match_s};
		end else begin
			diag_c = $signed({{PADW{1'b0}}, diag_in})
				+ {{(CAND_W-8){scores.mismatch_s[7]}}, scores.mismatch_s};
		end
		best = '0;
		mv   = MV_ORIGIN;
		if (left_c > best) begin
			best = left_c;
			mv   = MV_LEFT;
		end
		if (up_c > best) begin
			best = up_c;
			mv   = MV_UP;
		end
		if (diag_c > best) begin
			best = diag_c;
			mv   = MV_DIAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= flow_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_q <= b_in;
		end
		last_q <= flow_in.last_row;
		sym_q  <= flow_in.sym;
		row_q  <= row_in;
		if (clear) begin
			score_q <= '0;
			diag_q  <= '0;
		end else if (flow_in.valid) begin
			score_q <= best[SCORE_W-1:0];
			diag_q  <= score_q;
		end
	end

	// move column: written by the wavefront, read by the traceback
	always_ff @(posedge clk) begin
		if (flow_in.valid && !clear) begin
			mv_mem[row_in] <= mv;
		end
		rd_q <= mv_mem[rd_row];
	end

	assign flow_out  = '{valid: valid_q, last_row: last_q, sym: sym_q};
	assign row_out   = row_q;
	assign score_out = score_q;
	assign diag_out  = diag_q;
	assign rd_move   = rd_q;

endmodule

[rtl/swlg_trace.sv]
// Traceback walker, pair buffer and result output register.
module swlg_trace import swlg_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [$clog2(MAX_LEN+1)-1:0] first_len,
	input  logic [$clog2(MAX_LEN+1)-1:0] second_len,
	input  logic [1:0]                   move,
	input  logic [7:0]                   a_sym,
	input  logic [7:0]                   b_sym,
	output logic [$clog2(MAX_LEN+1)-1:0] row,
	output logic [$clog2(MAX_LEN+1)-1:0] col,
	output logic                         busy,
	output logic                         pair_valid,
	input  logic                         pair_stall,
	output logic [7:0]                   first_char,
	output logic [7:0]                   second_char,
	output logic                         none,
	output logic                         last
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int PB_D  = 2 * MAX_LEN;
	localparam int PB_W  = $clog2(PB_D);
	localparam int K_W   = $clog2(PB_D + 1);

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_WAITG = 3'd1;
	localparam logic [2:0] T_GATE  = 3'd2;
	localparam logic [2:0] T_WAIT  = 3'd3;
	localparam logic [2:0] T_EVAL  = 3'd4;
	localparam logic [2:0] T_OREAD = 3'd5;
	localparam logic [2:0] T_OLOAD = 3'd6;
	localparam logic [2:0] T_OHOLD = 3'd7;

	logic [2:0]       state_q;
	logic [LEN_W-1:0] i_q, j_q, ni, nj;
	logic [K_W-1:0]   k_q, k_nx;
	logic [PB_W-1:0]  rp_q;
	logic [15:0]      pbuf [PB_D];
	logic [15:0]      pb_rd_q;
	logic [1:0]       mv;
	logic [7:0]       a_c, b_c;
	logic             ov_q;

	always_comb begin
		if (i_q == '0 && j_q == '0) begin
			mv = MV_ORIGIN;
		end else if (i_q == '0) begin
			mv = MV_LEFT;
		end else if (j_q == '0) begin
			mv = MV_UP;
		end else begin
			mv = move;
		end
		ni = i_q;
		nj = j_q;
		case (mv)
			MV_LEFT: begin
				nj = j_q - 1'b1;
			end
			MV_UP: begin
				ni = i_q - 1'b1;
			end
			MV_DIAG: begin
				ni = i_q - 1'b1;
				nj = j_q - 1'b1;
			end
			default: begin
				ni = '0;
				nj = '0;
			end
		endcase
		a_c  = (ni < i_q) ? a_sym : GAP_CHAR;
		b_c  = (nj < j_q) ? b_sym : GAP_CHAR;
		k_nx = k_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			ov_q    <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (start) begin
						state_q <= T_WAITG;
					end
				end
				T_WAITG: begin
					state_q <= T_GATE;
				end
				T_GATE: begin
					if (ni != '0 && nj != '0) begin
						state_q <= T_EVAL;
					end else begin
						ov_q    <= 1'b1;
						state_q <= T_OHOLD;
					end
				end
				T_WAIT: begin
					state_q <= T_EVAL;
				end
				T_EVAL: begin
					if ((ni == '0 && nj == '0) || k_nx == K_W'(PB_D)) begin
						state_q <= T_OREAD;
					end else begin
						state_q <= T_WAIT;
					end
				end
				T_OREAD: begin
					state_q <= T_OLOAD;
				end
				T_OLOAD: begin
					ov_q    <= 1'b1;
					state_q <= T_OHOLD;
				end
				T_OHOLD: begin
					if (!pair_stall) begin
						ov_q    <= 1'b0;
						state_q <= last ? T_IDLE : T_OREAD;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pb_rd_q <= pbuf[rp_q];
		case (state_q)
			T_IDLE: begin
				i_q <= first_len;
				j_q <= second_len;
				k_q <= '0;
			end
			T_GATE: begin
				first_char  <= 8'd0;
				second_char <= 8'd0;
				none        <= 1'b1;
				last        <= 1'b1;
			end
			T_EVAL: begin
				pbuf[k_q[PB_W-1:0]] <= {a_c, b_c};
				rp_q <= k_q[PB_W-1:0];
				k_q  <= k_nx;
				i_q  <= ni;
				j_q  <= nj;
			end
			T_OLOAD: begin
				first_char  <= pb_rd_q[15:8];
				second_char <= pb_rd_q[7:0];
				none        <= 1'b0;
				last        <= (rp_q == '0);
			end
			T_OHOLD: begin
				if (!pair_stall && !last) begin
					rp_q <= rp_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign row        = i_q;
	assign col        = j_q;
	assign busy       = (state_q != T_IDLE);
	assign pair_valid = ov_q;

endmodule

[rtl/sequence_alignment_linear_gap.sv]
// Top level of the linear-gap sequence alignment block.
//
// Use: symbols arrive as beats on the command channel (cmd_valid/cmd_stall):
// cmd 0 appends to the first sequence, cmd 1 to the second (appends beyond
// MAX_LEN are dropped). cmd 2 aligns the stored sequences; cmd 3 is ignored.
// Scores come from three APB registers (match, mismatch, gap at 0x0, 0x4,
// 0x8); the user must write them only while idle, unchecked by the block.
//
// Align: the score matrix is filled by a chain of MAX_LEN column cells, rows
// fed from the first-sequence memory one per cycle. Traceback then alternates
// a wait and an evaluate step per pair (move column and symbol memories are
// read with a registered port), and each result beat leaves the pair buffer
// through a read, a load and a hold state, the last waiting out any stall.
//
// cmd_stall rises after an accepted align and stays high until the traceback
// is idle again after its last result beat has been taken; a stalled result
// holds its payload. Reset empties both sequences and restores the register
// defaults; no memory is cleared.
module sequence_alignment_linear_gap import swlg_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  symbol,
	output logic        pair_valid,
	input  logic        pair_stall,
	output logic [7:0]  first_char,
	output logic [7:0]  second_char,
	output logic        none,
	output logic        last
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W = $clog2(2 * MAX_LEN + 3);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_TRACE = 2'd2;

	logic [1:0]       state_q;
	swlg_scores_t     scores_q;
	logic [LEN_W-1:0] first_len_q, second_len_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cmd_acc, align_go, trace_start, trace_busy;

	// --- APB register file; pready tied high, writes land on the access beat
	logic [1:0] reg_idx;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scores_q <= '{match_s: 8'sd2, mismatch_s: -8'sd1, gap_s: -8'sd1};
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MATCH:    scores_q.match_s    <= pwdata[7:0];
				REG_MISMATCH: scores_q.mismatch_s <= pwdata[7:0];
				REG_GAP:      scores_q.gap_s      <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MATCH:    prdata = {24'd0, scores_q.match_s};
			REG_MISMATCH: prdata = {24'd0, scores_q.mismatch_s};
			REG_GAP:      prdata = {24'd0, scores_q.gap_s};
			default:      prdata = 32'd0;
		endcase
	end

	// --- command channel: only taken while nothing is in flight
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign align_go  = cmd_acc && (cmd == CMD_ALIGN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_len_q  <= '0;
			second_len_q <= '0;
			trace_start  <= 1'b0;
		end else begin
			trace_start <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd == CMD_FIRST && first_len_q != LEN_W'(MAX_LEN)) begin
						first_len_q <= first_len_q + 1'b1;
					end
					if (cmd_acc && cmd == CMD_SECOND
						&& second_len_q != LEN_W'(MAX_LEN)) begin
						second_len_q <= second_len_q + 1'b1;
					end
					if (align_go) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					// last cell has settled once the final row has crossed the chain
					if (cnt_q == CNT_W'(first_len_q) + CNT_W'(MAX_LEN + 1)) begin
						state_q     <= ST_TRACE;
						trace_start <= 1'b1;
					end
				end
				ST_TRACE: begin
					if (!trace_busy && !trace_start) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// --- row feeder: one first-sequence symbol per cycle into the chain head
	logic             feed_v_s1, feed_last_s1;
	logic [LEN_W-1:0] feed_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_v_s1 <= 1'b0;
		end else begin
			feed_v_s1 <= (state_q == ST_FILL) && (cnt_q < CNT_W'(first_len_q));
		end
	end

	always_ff @(posedge clk) begin
		if (align_go) begin
			cnt_q <= '0;
		end else if (state_q == ST_FILL) begin
			cnt_q <= cnt_q + 1'b1;
		end
		feed_row_s1  <= LEN_W'(cnt_q + 1'b1);
		feed_last_s1 <= (CNT_W'(cnt_q + 1'b1) == CNT_W'(first_len_q));
	end

	// --- sequence memories, one registered read port each
	logic [7:0]       first_mem  [MAX_LEN];
	logic [7:0]       second_mem [MAX_LEN];
	logic [7:0]       first_rd_q, second_rd_q;
	logic [LEN_W-1:0] tr_row, tr_col, row_m1, col_m1;
	logic [IDX_W-1:0] first_addr;

	assign row_m1     = tr_row - 1'b1;
	assign col_m1     = tr_col - 1'b1;
	assign first_addr = (state_q == ST_FILL) ? cnt_q[IDX_W-1:0] : row_m1[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd_acc && cmd == CMD_FIRST && first_len_q != LEN_W'(MAX_LEN)) begin
			first_mem[first_len_q[IDX_W-1:0]] <= symbol;
		end
		if (cmd_acc && cmd == CMD_SECOND && second_len_q != LEN_W'(MAX_LEN)) begin
			second_mem[second_len_q[IDX_W-1:0]] <= symbol;
		end
		first_rd_q  <= first_mem[first_addr];
		second_rd_q <= second_mem[col_m1[IDX_W-1:0]];
	end

	// --- cell chain; link 0 is the matrix border
	swlg_flow_t         flow   [MAX_LEN+1];
	logic [LEN_W-1:0]   row_ch [MAX_LEN+1];
	logic [SCORE_W-1:0] sc_ch  [MAX_LEN+1];
	logic [SCORE_W-1:0] dg_ch  [MAX_LEN+1];
	logic [1:0]         mv_rd  [MAX_LEN];

	assign flow[0]   = '{valid: feed_v_s1, last_row: feed_last_s1, sym: first_rd_q};
	assign row_ch[0] = feed_row_s1;
	assign sc_ch[0]  = '0;
	assign dg_ch[0]  = '0;

	for (genvar c = 0; c < MAX_LEN; c++) begin : g_cell
		swlg_cell #(.MAX_LEN(MAX_LEN)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear     (align_go),
			.b_we      (cmd_acc && cmd == CMD_SECOND && second_len_q == LEN_W'(c)),
			.b_in      (symbol),
			.scores    (scores_q),
			.last_col  (second_len_q == LEN_W'(c + 1)),
			.flow_in   (flow[c]),
			.row_in    (row_ch[c]),
			.left_in   (sc_ch[c]),
			.diag_in   (dg_ch[c]),
			.rd_row    (tr_row),
			.flow_out  (flow[c+1]),
			.row_out   (row_ch[c+1]),
			.score_out (sc_ch[c+1]),
			.diag_out  (dg_ch[c+1]),
			.rd_move   (mv_rd[c])
		);
	end

	// --- traceback and result output
	swlg_trace #(.MAX_LEN(MAX_LEN)) u_trace (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (trace_start),
		.first_len   (first_len_q),
		.second_len  (second_len_q),
		.move        (mv_rd[col_m1[IDX_W-1:0]]),
		.a_sym       (first_rd_q),
		.b_sym       (second_rd_q),
		.row         (tr_row),
		.col         (tr_col),
		.busy        (trace_busy),
		.pair_valid  (pair_valid),
		.pair_stall  (pair_stall),
		.first_char  (first_char),
		.second_char (second_char),
		.none        (none),
		.last        (last)
	);

endmodule

[rtl/swlg_checker.sv]
// Port-level checker for the alignment block, bound to the top level.
`include "sequence_alignment_linear_gap_assert.svh"

module swlg_checker import swlg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic [1:0]  cmd,
	input logic [7:0]  symbol,
	input logic        pair_valid,
	input logic        pair_stall,
	input logic [7:0]  first_char,
	input logic [7:0]  second_char,
	input logic        none,
	input logic        last
);

	// a stalled result beat holds
	`SWLG_ASSERT_NEXT(a_pair_hold, clk, arst_n, pair_valid && pair_stall, pair_valid && $stable({first_char, second_char, none, last}))

	// an empty alignment is a single beat
	`SWLG_ASSERT_NOW(a_none_last, clk, arst_n, pair_valid && none, last)

	// results only appear while the command side is held off
	`SWLG_ASSERT_NOW(a_busy_out, clk, arst_n, pair_valid, cmd_stall)

	// an accepted align blocks the command channel next cycle
	`SWLG_ASSERT_NEXT(a_align_busy, clk, arst_n, cmd_valid && !cmd_stall && cmd == CMD_ALIGN, cmd_stall)

endmodule

bind sequence_alignment_linear_gap swlg_checker u_swlg_checker (.*);

[test/tb_sequence_alignment_linear_gap.sv]
// Self-checking testbench for the linear-gap sequence alignment block.
`timescale 1ns / 1ps

module tb_sequence_alignment_linear_gap;
	import swlg_pkg::*;

	// cmd 3 has no name in the package; the block ignores it
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         SEQ_MAX    = MAX_LEN_DEF;
	localparam int         DIM        = SEQ_MAX + 1;
	// longest quiet spell: fill plus 64 pairs each held off by a full stall,
	// taken several times over
	localparam int         WATCHDOG_LIMIT = 6000;
	localparam int         SETTLE_CYCLES  = 12;

	typedef struct {
		logic [7:0] first_char;
		logic [7:0] second_char;
		logic       none;
		logic       last;
	} pair_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        cmd_valid;
	logic        cmd_stall;
	logic [1:0]  cmd;
	logic [7:0]  symbol;
	logic        pair_valid;
	logic        pair_stall;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic        none;
	logic        last;

	sequence_alignment_linear_gap dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.symbol      (symbol),
		.pair_valid  (pair_valid),
		.pair_stall  (pair_stall),
		.first_char  (first_char),
		.second_char (second_char),
		.none        (none),
		.last        (last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// Predictor state: our own copy of the sequences and the scores
	// ---------------------------------------------------------------
	logic signed [7:0] match_val;
	logic signed [7:0] mismatch_val;
	logic signed [7:0] gap_val;
	logic [7:0]        seq_a [SEQ_MAX];
	logic [7:0]        seq_b [SEQ_MAX];
	int                len_a;
	int                len_b;
	int                row_score [DIM];
	logic [1:0]        moves [DIM][DIM];

	pair_t expected_pairs[$];
	int    errors;
	bit    idle_enable;  // random gaps / stalls on both channels when set

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		errors++;
	endtask

	// Move taken out of cell (i, j); borders head straight for the origin
	function automatic logic [1:0] move_of(input int i, input int j);
		if (i == 0 && j == 0)
			return MV_ORIGIN;
		if (i == 0)
			return MV_LEFT;
		if (j == 0)
			return MV_UP;
		return moves[i][j];
	endfunction

	// Score fill, one row at a time, keeping only the row above
	task automatic fill_matrix();
		int diag;
		int left;
		int up;
		int best;
		int cand;
		logic [1:0] mv;
		for (int j = 0; j <= len_b; j++)
			row_score[j] = 0;
		for (int i = 1; i <= len_a; i++) begin
			diag = row_score[0];
			left = 0;
			row_score[0] = 0;
			for (int j = 1; j <= len_b; j++) begin
				up = row_score[j];
				best = 0;
				mv = MV_ORIGIN;
				// end gaps along the last row / column are free
				cand = left + ((i == len_a) ? 0 : int'(gap_val));
				if (cand > best) begin
					best = cand;
					mv = MV_LEFT;
				end
				cand = up + ((j == len_b) ? 0 : int'(gap_val));
				if (cand > best) begin
					best = cand;
					mv = MV_UP;
				end
				cand = diag + ((seq_a[i-1] == seq_b[j-1]) ? int'(match_val)
					: int'(mismatch_val));
				if (cand > best) begin
					best = cand;
					mv = MV_DIAG;
				end
				row_score[j] = best;
				moves[i][j] = mv;
				diag = up;
				left = best;
			end
		end
	endtask

	// Fill, trace back from the last cell and queue the pairs in forward order
	task automatic predict_alignment();
		pair_t trace[$];
		pair_t p;
		int i;
		int j;
		int ni;
		int nj;
		logic [1:0] mv;
		fill_matrix();
		i = len_a;
		j = len_b;
		mv = move_of(i, j);
		// trace only runs when the first step lands strictly inside the matrix
		if (mv == MV_DIAG && i > 1 && j > 1 || mv == MV_LEFT && i > 0 && j > 1
				|| mv == MV_UP && i > 1 && j > 0) begin
			while ((i > 0 || j > 0) && trace.size() < 2 * SEQ_MAX) begin
				mv = move_of(i, j);
				ni = i;
				nj = j;
				case (mv)
					MV_LEFT: nj = j - 1;
					MV_UP:   ni = i - 1;
					MV_DIAG: begin
						ni = i - 1;
						nj = j - 1;
					end
					default: begin
						ni = 0;
						nj = 0;
					end
				endcase
				p.first_char  = (ni < i) ? seq_a[i-1] : GAP_CHAR;
				p.second_char = (nj < j) ? seq_b[j-1] : GAP_CHAR;
				p.none = 1'b0;
				p.last = 1'b0;
				trace.push_front(p);
				i = ni;
				j = nj;
			end
		end
		if (trace.size() == 0) begin
			p.first_char  = 8'd0;
			p.second_char = 8'd0;
			p.none = 1'b1;
			p.last = 1'b1;
			expected_pairs.push_back(p);
		end else begin
			trace[trace.size()-1].last = 1'b1;
			foreach (trace[k])
				expected_pairs.push_back(trace[k]);
		end
	endtask

	// ---------------------------------------------------------------
	// Command channel
	// ---------------------------------------------------------------
	task automatic send_beat(input logic [1:0] c, input logic [7:0] s);
		int gap;
		gap = idle_enable ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		symbol <= s;
		do
			@(posedge clk);
		while (cmd_stall);
		case (c)
			CMD_FIRST: if (len_a < SEQ_MAX) begin
				seq_a[len_a] = s;
				len_a++;
			end
			CMD_SECOND: if (len_b < SEQ_MAX) begin
				seq_b[len_b] = s;
				len_b++;
			end
			CMD_ALIGN: predict_alignment();
			default: ;
		endcase
	endtask

	// Drop valid and let every outstanding pair drain before touching registers
	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic signed [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{24{val[7]}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MATCH:    match_val = val;
			REG_MISMATCH: mismatch_val = val;
			default:      gap_val = val;
		endcase
	endtask

	task automatic set_scores(input logic signed [7:0] m, input logic signed [7:0] mm,
			input logic signed [7:0] g);
		drain();
		write_reg(REG_MATCH, m);
		write_reg(REG_MISMATCH, mm);
		write_reg(REG_GAP, g);
	endtask

	// ---------------------------------------------------------------
	// Result channel: random back-pressure and the comparison
	// ---------------------------------------------------------------
	int hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (pair_valid && !pair_stall)
				hold_left = idle_enable ? $urandom_range(0, 6) : 0;
			else if (hold_left > 0)
				hold_left--;
			pair_stall <= (hold_left > 0);
		end
	end

	always @(posedge clk) begin
		pair_t exp_p;
		if (arst_n && pair_valid && !pair_stall) begin
			if (expected_pairs.size() == 0) begin
				report_mismatch("pending result count", 0, 1);
			end else begin
				exp_p = expected_pairs.pop_front();
				if (first_char !== exp_p.first_char)
					report_mismatch("first_char", exp_p.first_char, first_char);
				if (second_char !== exp_p.second_char)
					report_mismatch("second_char", exp_p.second_char, second_char);
				if (none !== exp_p.none)
					report_mismatch("none", exp_p.none, none);
				if (last !== exp_p.last)
					report_mismatch("last", exp_p.last, last);
			end
		end
	end

	// Watchdog: too long without any beat moving on either channel
	int quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (pair_valid && !pair_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Nothing loaded, then only the second sequence: both give the empty result
	task automatic test_empty_alignment();
		send_beat(CMD_ALIGN, 8'hA5);
		send_beat(CMD_UNUSED, 8'h5A);
		send_beat(CMD_SECOND, 8'h41);
		send_beat(CMD_ALIGN, 8'h00);
	endtask

	// Short sequences with byte extremes, aligned twice, then grown by one symbol each and aligned again
	task automatic test_short_sequences();
		send_beat(CMD_FIRST, 8'h00);
		send_beat(CMD_FIRST, 8'hFF);
		send_beat(CMD_FIRST, 8'h41);
		send_beat(CMD_FIRST, 8'h42);
		send_beat(CMD_SECOND, 8'h00);
		send_beat(CMD_SECOND, 8'hFF);
		send_beat(CMD_SECOND, 8'h42);
		send_beat(CMD_ALIGN, 8'h00);
		send_beat(CMD_ALIGN, 8'hFF);
		send_beat(CMD_UNUSED, 8'hFF);
		send_beat(CMD_FIRST, 8'h2D);
		send_beat(CMD_SECOND, 8'h2D);
		send_beat(CMD_ALIGN, 8'h00);
	endtask

	// Register extremes on the same short sequences
	task automatic test_score_extremes();
		set_scores(8'sd127, -8'sd128, -8'sd128);
		send_beat(CMD_ALIGN, 8'h00);
		set_scores(-8'sd128, 8'sd127, 8'sd127);
		send_beat(CMD_ALIGN, 8'h00);
		set_scores(-8'sd128, -8'sd128, -8'sd128);
		send_beat(CMD_ALIGN, 8'h00);
		set_scores(8'sd127, 8'sd127, 8'sd127);
		send_beat(CMD_ALIGN, 8'h00);
	endtask

	// Random phases: sequences grow to full length, scores change between phases
	task automatic test_random_phases();
		logic [1:0] c;
		logic [7:0] s;
		int pick;
		for (int ph = 0; ph < 12; ph++) begin
			idle_enable = (ph % 4 != 3);
			case (ph % 6)
				0: set_scores(8'sd2, -8'sd1, -8'sd1);
				1: set_scores(8'sd127, -8'sd128, -8'sd128);
				2: set_scores(-8'sd128, 8'sd127, -8'sd1);
				default: set_scores(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			for (int n = 0; n < 35; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					c = $urandom_range(0, 1) ? CMD_SECOND : CMD_FIRST;
				else if (pick < 75)
					c = CMD_UNUSED;
				else
					c = CMD_ALIGN;
				// a small alphabet makes matches common
				s = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(65, 68))
					: 8'($urandom_range(0, 255));
				send_beat(c, s);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		cmd = CMD_FIRST;
		symbol = 8'd0;
		errors = 0;
		idle_enable = 1'b1;
		match_val = 8'sd2;
		mismatch_val = -8'sd1;
		gap_val = -8'sd1;
		len_a = 0;
		len_b = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_alignment();
		test_short_sequences();
		test_score_extremes();
		test_random_phases();

		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/swlg_pkg.sv
rtl/swlg_cell.sv
rtl/swlg_trace.sv
rtl/sequence_alignment_linear_gap.sv
rtl/swlg_checker.sv
test/tb_sequence_alignment_linear_gap.sv
